>>> hw/rtl/vrsc_pkg.sv
package vrsc_pkg;

  localparam int unsigned BYTES_W = 32;

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_COMMIT  = 2'd1,
    REQ_END     = 2'd2,
    REQ_READY   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

endpackage

>>> hw/rtl/vector_register_scoreboard_chaining.sv
// A transaction is captured in the input register; as it leaves that register it is processed
// and its result is captured in the result register. Throughput: one transaction per cycle
// while the result register is drained (out_ready). The next transaction sees the tables as
// left by the previous one because they update as a transaction leaves the input register.
// Reset clears the reader/writer tables, dependency rows, occupied mask and count;
// byte counters and chain flags are written on allocation and are not reset.
module vector_register_scoreboard_chaining
  import vrsc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned NUM_VREGS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] read_regs,
  input  logic [31:0] write_regs,
  input  logic        chainable,
  input  logic [2:0]  slot,
  input  logic [15:0] commit_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [2:0]  granted_slot,
  output logic        ready_res,
  output logic        full_res,
  output logic [3:0]  pending_count
);

  localparam int unsigned SW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // input register
  logic        a_valid;
  req_type_t   a_type;
  logic [31:0] a_rd;
  logic [31:0] a_wr;
  logic        a_ch;
  logic [2:0]  a_slot;
  logic [15:0] a_nb;

  // state
  logic [QUEUE_DEPTH-1:0] readers_of_reg [NUM_VREGS];
  logic [QUEUE_DEPTH-1:0] writers_of_reg [NUM_VREGS];
  logic [QUEUE_DEPTH-1:0] input_deps     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] output_deps    [QUEUE_DEPTH];
  logic [BYTES_W-1:0]     bytes_done     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] slot_chainable;
  logic [QUEUE_DEPTH-1:0] slot_valid;
  logic [CW-1:0]          occupied_count;

  logic [QUEUE_DEPTH-1:0] readers_next [NUM_VREGS];
  logic [QUEUE_DEPTH-1:0] writers_next [NUM_VREGS];
  logic [QUEUE_DEPTH-1:0] input_deps_next  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] output_deps_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] slot_valid_next;
  logic [CW-1:0]          occupied_next;

  logic                   move;
  logic [QUEUE_DEPTH-1:0] slot_oh;
  logic                   sel_valid;
  logic [QUEUE_DEPTH-1:0] free_oh;
  logic [SW-1:0]          free_idx;
  logic                   have_free;
  logic [QUEUE_DEPTH-1:0] raw_mask;
  logic [QUEUE_DEPTH-1:0] waw_mask;
  logic [QUEUE_DEPTH-1:0] in_sel;
  logic [QUEUE_DEPTH-1:0] out_sel;
  logic [BYTES_W-1:0]     bytes_sel;
  logic                   chain_sel;
  logic                   chain_ok;
  logic                   enq_ok;
  logic                   commit_do;

  status_t                status_next;
  logic [2:0]             granted_next;
  logic                   ready_next;

  assign move     = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_type <= req_type_t'(req_type);
      a_rd   <= read_regs;
      a_wr   <= write_regs;
      a_ch   <= chainable;
      a_slot <= slot;
      a_nb   <= commit_bytes;
    end
  end

  // slot decode and selection
  always_comb begin
    slot_oh   = '0;
    in_sel    = '0;
    out_sel   = '0;
    bytes_sel = '0;
    chain_sel = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_oh[i] = (int'(a_slot) == i);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      in_sel    = in_sel    | ({QUEUE_DEPTH{slot_oh[i]}} & input_deps[i]);
      out_sel   = out_sel   | ({QUEUE_DEPTH{slot_oh[i]}} & output_deps[i]);
      bytes_sel = bytes_sel | ({BYTES_W{slot_oh[i]}} & bytes_done[i]);
      chain_sel = chain_sel | (slot_oh[i] & slot_chainable[i]);
    end
    sel_valid = |(slot_oh & slot_valid);
  end

  // lowest free slot
  always_comb begin
    free_idx  = '0;
    free_oh   = '0;
    have_free = |(~slot_valid);
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = SW'(i);
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      free_oh[i] = have_free && (int'(free_idx) == i);
    end
  end

  // dependency gathering
  always_comb begin
    raw_mask = '0;
    waw_mask = '0;
    for (int r = 0; r < NUM_VREGS; r++) begin
      if (a_rd[r]) begin
        raw_mask = raw_mask | writers_of_reg[r];
      end
      if (a_wr[r]) begin
        waw_mask = waw_mask | writers_of_reg[r] | readers_of_reg[r];
      end
    end
  end

  // chaining check
  always_comb begin
    chain_ok = chain_sel;
    for (int p = 0; p < QUEUE_DEPTH; p++) begin
      if (in_sel[p] && slot_valid[p]) begin
        if (!slot_chainable[p] || (bytes_done[p] <= bytes_sel)) begin
          chain_ok = 1'b0;
        end
      end
    end
  end

  // next state and result
  always_comb begin
    readers_next     = readers_of_reg;
    writers_next     = writers_of_reg;
    input_deps_next  = input_deps;
    output_deps_next = output_deps;
    slot_valid_next  = slot_valid;
    occupied_next    = occupied_count;
    status_next      = ST_OK;
    granted_next     = 3'd0;
    ready_next       = 1'b0;
    enq_ok           = 1'b0;
    commit_do        = 1'b0;
    unique case (a_type)
      REQ_ENQUEUE: begin
        if (!have_free) begin
          status_next = ST_FULL;
        end else begin
          enq_ok          = 1'b1;
          granted_next    = 3'(free_idx);
          slot_valid_next = slot_valid | free_oh;
          occupied_next   = occupied_count + CW'(1);
          for (int r = 0; r < NUM_VREGS; r++) begin
            if (a_rd[r]) begin
              readers_next[r] = readers_of_reg[r] | free_oh;
            end
            if (a_wr[r]) begin
              writers_next[r] = writers_of_reg[r] | free_oh;
            end
          end
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (free_oh[i]) begin
              input_deps_next[i]  = raw_mask & ~free_oh;
              output_deps_next[i] = waw_mask & ~free_oh;
            end
          end
        end
      end
      REQ_COMMIT: begin
        if (!sel_valid) begin
          status_next = ST_INVALID;
        end else begin
          commit_do = 1'b1;
        end
      end
      REQ_END: begin
        if (!sel_valid) begin
          status_next = ST_INVALID;
        end else begin
          for (int r = 0; r < NUM_VREGS; r++) begin
            readers_next[r] = readers_of_reg[r] & ~slot_oh;
            writers_next[r] = writers_of_reg[r] & ~slot_oh;
          end
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (slot_oh[i]) begin
              input_deps_next[i]  = '0;
              output_deps_next[i] = '0;
            end else begin
              input_deps_next[i]  = input_deps[i] & ~slot_oh;
              output_deps_next[i] = output_deps[i] & ~slot_oh;
            end
          end
          slot_valid_next = slot_valid & ~slot_oh;
          if (occupied_count != '0) begin
            occupied_next = occupied_count - CW'(1);
          end
        end
      end
      REQ_READY: begin
        if (!sel_valid) begin
          status_next = ST_INVALID;
        end else if (|(out_sel & slot_valid)) begin
          ready_next = 1'b0;
        end else if (!(|(in_sel & slot_valid))) begin
          ready_next = 1'b1;
        end else begin
          ready_next = chain_ok;
        end
      end
      default: begin
        status_next = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_VREGS; r++) begin
        readers_of_reg[r] <= '0;
        writers_of_reg[r] <= '0;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        input_deps[i]  <= '0;
        output_deps[i] <= '0;
      end
      slot_valid     <= '0;
      occupied_count <= '0;
    end else if (move) begin
      readers_of_reg <= readers_next;
      writers_of_reg <= writers_next;
      input_deps     <= input_deps_next;
      output_deps    <= output_deps_next;
      slot_valid     <= slot_valid_next;
      occupied_count <= occupied_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (enq_ok && free_oh[i]) begin
          bytes_done[i]     <= '0;
          slot_chainable[i] <= a_ch;
        end else if (commit_do && slot_oh[i]) begin
          bytes_done[i] <= bytes_done[i] + BYTES_W'(a_nb);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      status        <= status_next;
      granted_slot  <= granted_next;
      ready_res     <= ready_next;
      full_res      <= (32'(occupied_next) >= QUEUE_DEPTH);
      pending_count <= 4'(occupied_next);
    end
  end

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    32'(occupied_count) == $countones(slot_valid))
    else $error("occupied count disagrees with slot mask");

  a_enqueue_grows: assert property (@(posedge clk) disable iff (rst)
    move && a_type == REQ_ENQUEUE && have_free |=>
      occupied_count == $past(occupied_count) + CW'(1))
    else $error("accepted enqueue did not allocate a slot");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> full_res && granted_slot == 3'd0)
    else $error("queue-full refusal with inconsistent result");

  a_ready_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && ready_res |-> status == ST_OK)
    else $error("ready reported for a refused transaction");

endmodule
